/* design/nsc_pkg.sv */
// Shared types, constants and helper functions for the NMEA sentence capture block.
package nsc_pkg;

    typedef enum logic [1:0] {
        MODE_BYTE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_GOT1 = 3'd1,
        ST_GOT2 = 3'd2,
        ST_GOT3 = 3'd3,
        ST_CAPT = 3'd4
    } t_match_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  rx_byte;
        logic [15:0] adc_sample;
        logic [6:0]  read_index;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       frame_ready;
        logic [7:0] frame_length;
        logic [2:0] match_state;
    } t_rsp;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_N      = 8'h4e;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;

    localparam int unsigned HDR_LEN    = 4;
    localparam int unsigned SUFFIX_LEN = 5;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        begin
            wide = {4'h0, nib};
            hex_digit = (nib < 4'd10) ? (wide + 8'h30) : (wide + 8'h57);
        end
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] b;
        begin
            unique case (pos)
                2'd0:    b = CH_DOLLAR;
                2'd1:    b = CH_G;
                2'd2:    b = CH_N;
                default: b = CH_R;
            endcase
            hdr_byte = b;
        end
    endfunction

    function automatic logic [7:0] sfx_byte(input logic [2:0] off, input logic [15:0] smp);
        logic [7:0] b;
        begin
            case (off)
                3'd0:    b = CH_SLASH;
                3'd1:    b = hex_digit(smp[15:12]);
                3'd2:    b = hex_digit(smp[11:8]);
                3'd3:    b = hex_digit(smp[7:4]);
                default: b = hex_digit(smp[3:0]);
            endcase
            sfx_byte = b;
        end
    endfunction

endpackage

/* design/nmea_sentence_capture.sv */
// Top level of the NMEA sentence capture block: header matcher, frame memory and output stage.
//
//   Channel | Direction | Handshake          | Payload
//   request | in        | i_valid / o_ready  | i_req (nsc_pkg::t_req)
//   result  | out       | o_valid / i_ready  | o_rsp (nsc_pkg::t_rsp)
//
// One request is taken per cycle if o_ready is high; results pass the s1 and output registers.
// The frame memory has one write and one registered read port, used by byte and read requests.
// The header and the tag suffix are produced from logic, so each request needs at most one port access.
// Synchronous active-low reset clears the matcher, counters and flags; memory is not cleared.
// A stalled result holds in the output register while one more request waits in the read stage.
module nmea_sentence_capture #(
    parameter int unsigned BUF_DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  nsc_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output nsc_pkg::t_rsp o_rsp
);
    import nsc_pkg::*;

    localparam int unsigned AW = $clog2(BUF_DEPTH);
    localparam int unsigned PW = $clog2(BUF_DEPTH + 1);
    localparam int unsigned CW = (PW > 7) ? PW : 7;
    localparam int unsigned LW = (PW > 8) ? PW : 8;
    localparam logic [PW-1:0] WP_MAX = PW'(BUF_DEPTH - SUFFIX_LEN);

    logic [7:0] mem [BUF_DEPTH];

    t_match_state r_state, n_state;
    logic [PW-1:0] r_wp, n_wp;
    logic          r_ready, n_ready;
    logic [15:0]   r_held, n_held;
    logic          r_sfx, n_sfx;

    logic          r_s1_vld;
    logic          r_s1_sel_mem;
    logic [7:0]    r_s1_byte;
    t_rsp          r_s1_rsp;
    logic [7:0]    r_rd;

    logic          r_o_vld;
    t_rsp          r_o;

    logic          acc;
    logic          s1_adv;
    t_mode         mode;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [PW-1:0] cr_pos;

    logic [CW-1:0] idx_c;
    logic [CW-1:0] wp_c;
    logic [CW:0]   idx_sum;
    logic [CW-1:0] sfx_off;
    logic          in_frame;
    logic          rd_sel_mem;
    logic [7:0]    rd_byte;
    logic [LW-1:0] len_l;
    t_rsp          n_s1_rsp;
    t_rsp          s1_out;

    assign s1_adv  = r_s1_vld && (!r_o_vld || i_ready);
    assign o_ready = !r_s1_vld || s1_adv;
    assign acc     = i_valid && o_ready;
    assign mode    = t_mode'(i_req.mode);
    assign o_valid = r_o_vld;
    assign o_rsp   = r_o;

    assign mem_wa = r_wp[AW-1:0];
    assign cr_pos = (r_wp > WP_MAX) ? WP_MAX : r_wp;

    always_comb begin
        n_state = r_state;
        n_wp    = r_wp;
        n_ready = r_ready;
        n_held  = r_held;
        n_sfx   = r_sfx;
        mem_we  = 1'b0;
        if (acc) begin
            unique case (mode)
                MODE_BYTE: begin
                    unique case (r_state)
                        ST_IDLE: begin
                            if (i_req.rx_byte == CH_DOLLAR && !r_ready) begin
                                n_state = ST_GOT1;
                            end
                        end
                        ST_GOT1: n_state = (i_req.rx_byte == CH_G) ? ST_GOT2 : ST_IDLE;
                        ST_GOT2: n_state = (i_req.rx_byte == CH_N) ? ST_GOT3 : ST_IDLE;
                        ST_GOT3: begin
                            if (i_req.rx_byte == CH_R) begin
                                n_state = ST_CAPT;
                                n_wp    = PW'(HDR_LEN);
                                n_sfx   = 1'b0;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        ST_CAPT: begin
                            if (i_req.rx_byte != CH_CR) begin
                                if (r_wp < WP_MAX) begin
                                    mem_we = 1'b1;
                                    n_wp   = r_wp + PW'(1);
                                end
                            end else begin
                                n_wp    = cr_pos + PW'(SUFFIX_LEN);
                                n_held  = i_req.adc_sample;
                                n_ready = 1'b1;
                                n_sfx   = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
                MODE_CLEAR: n_ready = 1'b0;
                default: ;
            endcase
        end
    end

    assign idx_c    = CW'(i_req.read_index);
    assign wp_c     = CW'(r_wp);
    assign idx_sum  = {1'b0, idx_c} + (CW + 1)'(SUFFIX_LEN);
    assign sfx_off  = idx_c + CW'(SUFFIX_LEN) - wp_c;
    assign in_frame = idx_c < wp_c;
    assign mem_ra   = idx_c[AW-1:0];

    always_comb begin
        rd_sel_mem = 1'b0;
        rd_byte    = 8'h00;
        if (mode == MODE_READ && in_frame) begin
            if (idx_c < CW'(HDR_LEN)) begin
                rd_byte = hdr_byte(idx_c[1:0]);
            end else if (r_sfx && idx_sum >= {1'b0, wp_c}) begin
                rd_byte = sfx_byte(sfx_off[2:0], r_held);
            end else begin
                rd_sel_mem = 1'b1;
            end
        end
    end

    assign len_l = LW'(n_wp);

    always_comb begin
        n_s1_rsp              = '0;
        n_s1_rsp.frame_ready  = n_ready;
        n_s1_rsp.frame_length = n_ready ? len_l[7:0] : 8'h00;
        n_s1_rsp.match_state  = n_state;
    end

    always_comb begin
        s1_out           = r_s1_rsp;
        s1_out.read_data = r_s1_sel_mem ? r_rd : r_s1_byte;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= i_req.rx_byte;
        end
        if (acc) begin
            r_rd <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_ready <= 1'b0;
            r_held  <= '0;
            r_sfx   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_ready <= n_ready;
            r_held  <= n_held;
            r_sfx   <= n_sfx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_sel_mem <= rd_sel_mem;
            r_s1_byte    <= rd_byte;
            r_s1_rsp     <= n_s1_rsp;
        end
        if (s1_adv) begin
            r_o <= s1_out;
        end
    end

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= PW'(BUF_DEPTH))
        else $error("write position beyond buffer depth");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == ST_IDLE))
        else $error("frame ready while matcher is active");

    a_ready_sfx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_sfx && r_wp >= PW'(HDR_LEN + SUFFIX_LEN)))
        else $error("frame ready without a complete suffix");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_o_vld && !i_ready) |-> !o_ready)
        else $error("request taken while both stages are stalled");

endmodule
